>>> rtl/core/assert_macros.svh
// Assertion macros for the core RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Invariant that holds on every checked edge
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

>>> rtl/core/adtfp_pkg.sv
// Constants, types and tables for the ASCII decimal to fixed-point core
package adtfp_pkg;

    // Number of fraction digits carried in the fixed-point result (1..18)
    localparam int unsigned PRECISION = 8;

    // Power of ten, evaluated at elaboration
    function automatic logic [63:0] pow10(input int unsigned n);
        logic [63:0] r;
        r = 64'd1;
        for (int unsigned i = 0; i < n; i++) begin
            r = r * 64'd10;
        end
        return r;
    endfunction

    localparam logic [63:0] WHOLE_SCALE = pow10(PRECISION);
    localparam int unsigned FRAC_W      = $clog2(WHOLE_SCALE);
    localparam int unsigned CNT_W       = $clog2(PRECISION + 1);
    localparam int unsigned WS_W        = 64;
    localparam int unsigned WS_NEXT_W   = WS_W + 4;
    localparam int unsigned MAG_W       = WS_W + 1;

    // Magnitude cap and saturation values
    localparam logic [WS_W-1:0] WS_CAP  = 64'h8000_0000_0000_0000;
    localparam logic [WS_W-1:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [WS_W-1:0] SAT_NEG = 64'h8000_0000_0000_0000;

    // Character codes
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef logic [FRAC_W-1:0] t_frac;
    typedef t_frac t_weight_tbl [2**CNT_W];

    // Weight of the fraction digit at each position; zero past the last one
    function automatic t_weight_tbl frac_weights();
        t_weight_tbl t;
        for (int unsigned c = 0; c < 2**CNT_W; c++) begin
            if (c < PRECISION) begin
                t[c] = FRAC_W'(pow10(PRECISION - 1 - c));
            end else begin
                t[c] = '0;
            end
        end
        return t;
    endfunction

    localparam t_weight_tbl FRAC_WEIGHT = frac_weights();

    // Parser phase
    typedef enum logic [1:0] {
        PH_SKIP,
        PH_INT,
        PH_FRAC,
        PH_STOP
    } t_phase;

endpackage

>>> rtl/core/ascii_decimal_to_fixed_point_core.sv
// ASCII decimal string to signed fixed-point converter, top level
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_ready   i_char_code, i_end_of_text
//  output    out        o_valid / i_ready   o_fixed_value, o_overflow
//
// One character per cycle, but a last character waits while the finish stage is full;
// the limit is the multiply-by-ten accumulate loop in the parse stage.
// The input, finish and output registers carry a result in that order.
// Characters keep flowing while a result waits; only a last character waits
// for the finish stage to be free.
// Synchronous active-low reset clears all control and parser state.
`include "assert_macros.svh"

module ascii_decimal_to_fixed_point_core
    import adtfp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_char_code,
    input  logic            i_end_of_text,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [WS_W-1:0] o_fixed_value,
    output logic            o_overflow
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_last;

    // Parser state
    t_phase          r_phase, n_phase;
    logic            r_neg, n_neg;
    logic [WS_W-1:0] r_ws, n_ws;      // whole part already times 10^PRECISION
    t_frac           r_frac, n_frac;  // fraction already scaled
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic            r_big, n_big;    // magnitude passed the cap

    // Finish register
    logic            r_fin_valid;
    logic            r_fin_neg;
    logic [WS_W-1:0] r_fin_ws;
    t_frac           r_fin_frac;
    logic            r_fin_big;

    // Output register
    logic            r_out_valid;
    logic [WS_W-1:0] r_out_value;
    logic            r_out_ovf;

    // Flow control
    logic out_free, fin_free, parse_go, in_free;

    assign out_free = !r_out_valid || i_ready;
    assign fin_free = !r_fin_valid || out_free;
    assign parse_go = r_in_valid && (!r_last || fin_free);
    assign in_free  = !r_in_valid || parse_go;
    assign o_ready  = in_free;

    // Character classes
    logic       is_digit, is_space;
    logic [3:0] digit;

    assign is_digit = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
    assign is_space = (r_char == CH_SPACE) || ((r_char >= CH_TAB) && (r_char <= CH_CR));
    assign digit    = 4'(r_char - CH_ZERO);

    // Phase next state
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_SKIP: begin
                if (is_space) begin
                    n_phase = PH_SKIP;
                end else if (r_char == CH_MINUS || r_char == CH_PLUS || is_digit) begin
                    n_phase = PH_INT;
                end else if (r_char == CH_DOT) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_STOP;
                end
            end
            PH_INT: begin
                if (is_digit) begin
                    n_phase = PH_INT;
                end else if (r_char == CH_DOT) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_STOP;
                end
            end
            PH_FRAC: begin
                if (is_digit && r_cnt < CNT_W'(PRECISION)) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_STOP;
                end
            end
            PH_STOP: begin
                n_phase = PH_STOP;
            end
            default: begin
                n_phase = PH_STOP;
            end
        endcase
    end

    // Datapath controls decoded from the phase
    logic take_whole, take_frac, set_neg;

    always_comb begin
        take_whole = 1'b0;
        take_frac  = 1'b0;
        set_neg    = 1'b0;
        unique case (r_phase)
            PH_SKIP: begin
                take_whole = is_digit;
                set_neg    = (r_char == CH_MINUS);
            end
            PH_INT: begin
                take_whole = is_digit;
            end
            PH_FRAC: begin
                take_frac = is_digit && (r_cnt < CNT_W'(PRECISION));
            end
            PH_STOP: begin
                take_whole = 1'b0;
            end
            default: begin
                take_whole = 1'b0;
            end
        endcase
    end

    // Scaled whole accumulate: ws*10 + digit*10^PRECISION, capped
    logic [WS_NEXT_W-1:0] ws_next;
    logic                 ws_over;
    t_frac                frac_add;

    assign ws_next  = (WS_NEXT_W'(r_ws) << 3) + (WS_NEXT_W'(r_ws) << 1)
                    + (WS_NEXT_W'(WHOLE_SCALE) * WS_NEXT_W'(digit));
    assign ws_over  = ws_next > WS_NEXT_W'(WS_CAP);
    assign frac_add = FRAC_WEIGHT[r_cnt] * FRAC_W'(digit);

    always_comb begin
        n_neg  = r_neg || set_neg;
        n_ws   = r_ws;
        n_big  = r_big;
        n_frac = r_frac;
        n_cnt  = r_cnt;
        if (take_whole && !r_big) begin
            if (ws_over) begin
                n_big = 1'b1;
            end else begin
                n_ws = ws_next[WS_W-1:0];
            end
        end
        if (take_frac) begin
            n_frac = r_frac + frac_add;
            n_cnt  = r_cnt + CNT_W'(1);
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_valid;
        end
        if (in_free && i_valid) begin
            r_char <= i_char_code;
            r_last <= i_end_of_text;
        end
    end

    // Parser state; cleared after the last character of a string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (parse_go && r_last)) begin
            r_phase <= PH_SKIP;
            r_neg   <= 1'b0;
            r_ws    <= '0;
            r_frac  <= '0;
            r_cnt   <= '0;
            r_big   <= 1'b0;
        end else if (parse_go) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_ws    <= n_ws;
            r_frac  <= n_frac;
            r_cnt   <= n_cnt;
            r_big   <= n_big;
        end
    end

    // Finish register: final parser state of one string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (fin_free) begin
            r_fin_valid <= parse_go && r_last;
        end
        if (fin_free && parse_go && r_last) begin
            r_fin_neg  <= n_neg;
            r_fin_ws   <= n_ws;
            r_fin_frac <= n_frac;
            r_fin_big  <= n_big;
        end
    end

    // Combine, range check, sign
    logic [MAG_W-1:0] mag, limit;
    logic             fin_ovf;
    logic [WS_W-1:0]  fin_value;

    always_comb begin
        mag     = MAG_W'(r_fin_ws) + MAG_W'(r_fin_frac);
        limit   = r_fin_neg ? MAG_W'(WS_CAP) : MAG_W'(SAT_POS);
        fin_ovf = r_fin_big || (mag > limit);
        if (fin_ovf) begin
            fin_value = r_fin_neg ? SAT_NEG : SAT_POS;
        end else if (r_fin_neg) begin
            fin_value = WS_W'(-mag);
        end else begin
            fin_value = mag[WS_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_fin_valid;
        end
        if (out_free && r_fin_valid) begin
            r_out_value <= fin_value;
            r_out_ovf   <= fin_ovf;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_fixed_value = r_out_value;
    assign o_overflow    = r_out_ovf;

    // Checks
    `ASSERT_IMPL(a_ovf_saturates, i_clk, i_rst_n, r_out_valid && r_out_ovf,
        r_out_value == SAT_POS || r_out_value == SAT_NEG, "overflow without saturated value")
    `ASSERT_NEXT(a_fin_held, i_clk, i_rst_n, r_fin_valid && !out_free,
        r_fin_valid && r_out_valid, "pending string result dropped")
    `ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, parse_go && r_last,
        r_phase == PH_SKIP && r_ws == '0 && !r_big && r_cnt == '0, "parser not cleared")
    `ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= CNT_W'(PRECISION),
        "fraction digit count out of range")

endmodule
